>>> rtl/mvt_pkg.sv
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_Z = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TINT   = 4'd7;

  localparam logic [47:0] ROT_X_RST = 48'd16384;
  localparam logic [47:0] ROT_Y_RST = 48'd1073741824;
  localparam logic [47:0] ROT_Z_RST = 48'd70368744177664;
  localparam logic [47:0] SCALE_RST = 48'd1099528405248;
  localparam logic [35:0] TINT_RST  = 36'd34426978560;

  localparam logic [7:0] BYTE_MAX     = 8'hFF;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic [31:0]        colour_in;
    logic               colour_present;
    logic               last_vertex;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_nrm_x;
    logic signed [15:0] out_nrm_y;
    logic signed [15:0] out_nrm_z;
    logic [31:0]        colour_out;
    logic               out_last;
  } vtx_out_t;

endpackage

>>> rtl/mesh_vertex_transform_core.sv
`timescale 1ns / 1ps

// Vertex transform: scale, 3x3 rotate and translate the position, rotate the
// normal, tint the colour. Four register stages (scale multiply, matrix
// multiplies, row sums, shift/offset/saturate); one vertex enters every cycle
// when nothing stalls, and its result leaves from the last stage. Each stage
// holds its beat under out_stall and a bubble anywhere in the pipe lets a new
// beat in. The stage-two product array (nine 16x40 and nine 16x16 multipliers)
// sets the clock. Configuration writes are always taken (cfg_ready high) and
// must only be issued while the pipe is empty.
module mesh_vertex_transform_core
  import mvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vtx_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vtx_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [47:0]        rot [3];
  logic [47:0]        scale;
  logic signed [31:0] offs [3];
  logic [35:0]        tint;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]  <= ROT_X_RST;
      rot[1]  <= ROT_Y_RST;
      rot[2]  <= ROT_Z_RST;
      scale   <= SCALE_RST;
      offs[0] <= '0;
      offs[1] <= '0;
      offs[2] <= '0;
      tint    <= TINT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT_X:  rot[0]  <= cfg_data;
        REG_ROT_Y:  rot[1]  <= cfg_data;
        REG_ROT_Z:  rot[2]  <= cfg_data;
        REG_SCALE:  scale   <= cfg_data;
        REG_OFFS_X: offs[0] <= cfg_data[31:0];
        REG_OFFS_Y: offs[1] <= cfg_data[31:0];
        REG_OFFS_Z: offs[2] <= cfg_data[31:0];
        REG_TINT:   tint    <= cfg_data[35:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [3:0] vld;
  logic [3:0] rdy;

  assign rdy[3]    = !vld[3] || !out_stall;
  assign rdy[2]    = !vld[2] || rdy[3];
  assign rdy[1]    = !vld[1] || rdy[2];
  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_stall  = !rdy[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  // stage 1: per-axis scale, colour
  logic signed [31:0] pos [3];
  logic signed [15:0] nrm_in [3];
  logic signed [47:0] sprod [3];
  logic signed [39:0] s1_s [3];
  logic signed [15:0] s1_n [3];
  logic [31:0]        s1_colour;
  logic [31:0]        colour_next;
  logic               s1_last;
  logic [16:0]        cprod [4];
  logic [16:0]        gprod [3];

  assign pos[0]    = in_data.pos_x;
  assign pos[1]    = in_data.pos_y;
  assign pos[2]    = in_data.pos_z;
  assign nrm_in[0] = in_data.nrm_x;
  assign nrm_in[1] = in_data.nrm_y;
  assign nrm_in[2] = in_data.nrm_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sprod[i] = pos[i] * $signed(scale[16*i +: 16]);
    end
    for (int i = 0; i < 4; i++) begin
      cprod[i] = in_data.colour_in[8*i +: 8] * tint[9*i +: 9];
    end
    for (int i = 0; i < 3; i++) begin
      gprod[i] = tint[9*i +: 9] * BYTE_MAX;
    end
    if (in_data.colour_present) begin
      for (int i = 0; i < 4; i++) begin
        colour_next[8*i +: 8] = cprod[i][16] ? BYTE_MAX : cprod[i][15:8];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        colour_next[8*i +: 8] = gprod[i][16] ? BYTE_MAX : gprod[i][15:8];
      end
      colour_next[31:24] = ALPHA_OPAQUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_s[i] <= sprod[i][47:8];
        s1_n[i] <= nrm_in[i];
      end
      s1_colour <= colour_next;
      s1_last   <= in_data.last_vertex;
    end
  end

  // stage 2: matrix products
  logic signed [55:0] s2_pp [3][3];
  logic signed [31:0] s2_np [3][3];
  logic [31:0]        s2_colour;
  logic               s2_last;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s2_pp[i][j] <= $signed(rot[i][16*j +: 16]) * s1_s[j];
          s2_np[i][j] <= $signed(rot[i][16*j +: 16]) * s1_n[j];
        end
      end
      s2_colour <= s1_colour;
      s2_last   <= s1_last;
    end
  end

  // stage 3: row sums
  logic signed [57:0] s3_accp [3];
  logic signed [33:0] s3_accn [3];
  logic [31:0]        s3_colour;
  logic               s3_last;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        s3_accp[i] <= 58'(s2_pp[i][0]) + 58'(s2_pp[i][1]) + 58'(s2_pp[i][2]);
        s3_accn[i] <= 34'(s2_np[i][0]) + 34'(s2_np[i][1]) + 34'(s2_np[i][2]);
      end
      s3_colour <= s2_colour;
      s3_last   <= s2_last;
    end
  end

  // stage 4: drop fraction (floor), offset, saturate
  logic signed [44:0] rpos [3];
  logic signed [19:0] rnrm [3];
  logic signed [31:0] pos_next [3];
  logic signed [15:0] nrm_next [3];
  logic signed [31:0] s4_pos [3];
  logic signed [15:0] s4_nrm [3];
  logic [31:0]        s4_colour;
  logic               s4_last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rpos[i] = 45'($signed(s3_accp[i][57:14])) + 45'(offs[i]);
      if (rpos[i][44:31] == {14{rpos[i][31]}}) begin
        pos_next[i] = rpos[i][31:0];
      end else begin
        pos_next[i] = rpos[i][44] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end
      rnrm[i] = s3_accn[i][33:14];
      if (rnrm[i][19:15] == {5{rnrm[i][15]}}) begin
        nrm_next[i] = rnrm[i][15:0];
      end else begin
        nrm_next[i] = rnrm[i][19] ? {1'b1, 15'd0} : {1'b0, {15{1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        s4_pos[i] <= pos_next[i];
        s4_nrm[i] <= nrm_next[i];
      end
      s4_colour <= s3_colour;
      s4_last   <= s3_last;
    end
  end

  assign out_data.out_pos_x  = s4_pos[0];
  assign out_data.out_pos_y  = s4_pos[1];
  assign out_data.out_pos_z  = s4_pos[2];
  assign out_data.out_nrm_x  = s4_nrm[0];
  assign out_data.out_nrm_y  = s4_nrm[1];
  assign out_data.out_nrm_z  = s4_nrm[2];
  assign out_data.colour_out = s4_colour;
  assign out_data.out_last   = s4_last;

`ifndef NO_ASSERTIONS
  // a bubble at the output stage opens the whole pipe
  a_bubble_accepts: assert property (@(posedge clk) disable iff (rst)
    !vld[3] |-> !in_stall)
    else $error("input stalled with empty output stage");

  // a beat held in stage 3 keeps its sums
  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && !rdy[2]) |=> (vld[2] && $stable(s3_accp[0]) && $stable(s3_colour)))
    else $error("stage 3 beat changed while held");

  // pipe is empty on the first cycle out of reset
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (vld == 4'd0))
    else $error("pipeline not empty after reset");

  // any stall upstream needs every stage full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld == 4'hF) && out_stall)
    else $error("input stalled with a bubble in the pipe");
`endif

endmodule

>>> verif/mesh_vertex_transform_checker.sv
`timescale 1ns / 1ps

module mesh_vertex_transform_checker
  import mvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  vtx_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  vtx_out_t              out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    in_flight
);

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint NRM_MAX = 64'sd32767;
  localparam longint NRM_MIN = -64'sd32768;

  logic [47:0] rot_r [3];
  logic [47:0] scale_r;
  logic [31:0] offs_r [3];
  logic [35:0] tint_r;

  vtx_out_t expected_vertices [$];

  initial begin
    fail_count = 0;
    in_flight  = 0;
  end

  function automatic vtx_out_t transform_vertex(vtx_in_t v);
    longint pos [3];
    longint nrm [3];
    longint scaled [3];
    longint acc_p, acc_n, m, r, t;
    logic [31:0] res_pos [3];
    logic [15:0] res_nrm [3];
    logic [31:0] colour;
    vtx_out_t o;
    pos[0] = v.pos_x;
    pos[1] = v.pos_y;
    pos[2] = v.pos_z;
    nrm[0] = v.nrm_x;
    nrm[1] = v.nrm_y;
    nrm[2] = v.nrm_z;
    // Q16.16 * Q8.8, drop 8 fraction bits (floor)
    for (int i = 0; i < 3; i++) begin
      scaled[i] = (pos[i] * longint'($signed(scale_r[16*i +: 16]))) >>> 8;
    end
    for (int i = 0; i < 3; i++) begin
      acc_p = 0;
      acc_n = 0;
      for (int j = 0; j < 3; j++) begin
        m = longint'($signed(rot_r[i][16*j +: 16]));
        acc_p += m * scaled[j];
        acc_n += m * nrm[j];
      end
      r = (acc_p >>> 14) + longint'($signed(offs_r[i]));
      r = (r > POS_MAX) ? POS_MAX : ((r < POS_MIN) ? POS_MIN : r);
      res_pos[i] = r[31:0];
      r = acc_n >>> 14;
      r = (r > NRM_MAX) ? NRM_MAX : ((r < NRM_MIN) ? NRM_MIN : r);
      res_nrm[i] = r[15:0];
    end
    for (int k = 0; k < 4; k++) begin
      t = tint_r[9*k +: 9];
      if (v.colour_present)
        r = (longint'(v.colour_in[8*k +: 8]) * t) >> 8;
      else
        r = (t * BYTE_MAX) >> 8;
      if (r > BYTE_MAX)
        r = BYTE_MAX;
      colour[8*k +: 8] = r[7:0];
    end
    // generated colour is always opaque; alpha tint unused
    if (!v.colour_present)
      colour[31:24] = ALPHA_OPAQUE;
    o.out_pos_x  = res_pos[0];
    o.out_pos_y  = res_pos[1];
    o.out_pos_z  = res_pos[2];
    o.out_nrm_x  = res_nrm[0];
    o.out_nrm_y  = res_nrm[1];
    o.out_nrm_z  = res_nrm[2];
    o.colour_out = colour;
    o.out_last   = v.last_vertex;
    return o;
  endfunction

  task automatic check_field(string fld, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, fld, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    vtx_out_t want;
    if (rst) begin
      rot_r[0] <= ROT_X_RST;
      rot_r[1] <= ROT_Y_RST;
      rot_r[2] <= ROT_Z_RST;
      scale_r  <= SCALE_RST;
      offs_r[0] <= '0;
      offs_r[1] <= '0;
      offs_r[2] <= '0;
      tint_r   <= TINT_RST;
      expected_vertices.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat %h", $realtime, out_data);
        end else begin
          want = expected_vertices.pop_front();
          check_field("out_pos_x", want.out_pos_x, out_data.out_pos_x);
          check_field("out_pos_y", want.out_pos_y, out_data.out_pos_y);
          check_field("out_pos_z", want.out_pos_z, out_data.out_pos_z);
          check_field("out_nrm_x", want.out_nrm_x, out_data.out_nrm_x);
          check_field("out_nrm_y", want.out_nrm_y, out_data.out_nrm_y);
          check_field("out_nrm_z", want.out_nrm_z, out_data.out_nrm_z);
          check_field("colour_out", want.colour_out, out_data.colour_out);
          check_field("out_last", want.out_last, out_data.out_last);
        end
      end
      // predict with the registers as they stood before any write at this edge
      if (in_valid && !in_stall)
        expected_vertices.insert(expected_vertices.size(), transform_vertex(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_X:  rot_r[0]  <= cfg_data[47:0];
          REG_ROT_Y:  rot_r[1]  <= cfg_data[47:0];
          REG_ROT_Z:  rot_r[2]  <= cfg_data[47:0];
          REG_SCALE:  scale_r   <= cfg_data[47:0];
          REG_OFFS_X: offs_r[0] <= cfg_data[31:0];
          REG_OFFS_Y: offs_r[1] <= cfg_data[31:0];
          REG_OFFS_Z: offs_r[2] <= cfg_data[31:0];
          REG_TINT:   tint_r    <= cfg_data[35:0];
          default: ;
        endcase
      end
    end
    in_flight <= expected_vertices.size();
  end

endmodule

>>> verif/mesh_vertex_transform_core_tb.sv
`timescale 1ns / 1ps

module mesh_vertex_transform_core_tb;
  import mvt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 250;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid;
  logic                  in_stall;
  vtx_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  vtx_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic quiet = 1'b0;
  int   fail_count;
  int   in_flight;
  int   cycle_count = 0;

  mesh_vertex_transform_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mesh_vertex_transform_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mesh_vertex_transform_core_tb failed");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic signed [31:0] pick_pos();
    case ($urandom_range(7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(32'h000FFFFF)) - 32'sd524288;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_nrm();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return w[0] ? 16'sh4000 : -16'sh4000;
      default: return w[15:0];
    endcase
  endfunction

  function automatic vtx_in_t rand_vertex();
    vtx_in_t v;
    v.pos_x          = pick_pos();
    v.pos_y          = pick_pos();
    v.pos_z          = pick_pos();
    v.nrm_x          = pick_nrm();
    v.nrm_y          = pick_nrm();
    v.nrm_z          = pick_nrm();
    v.colour_in      = $urandom;
    v.colour_present = ($urandom_range(3) != 0);
    v.last_vertex    = ($urandom_range(7) == 0);
    return v;
  endfunction

  function automatic vtx_in_t make_vertex(logic signed [31:0] p, logic signed [15:0] n,
                                          logic [31:0] c, logic present, logic last);
    vtx_in_t v;
    v.pos_x          = p;
    v.pos_y          = ~p;
    v.pos_z          = p;
    v.nrm_x          = n;
    v.nrm_y          = ~n;
    v.nrm_z          = n;
    v.colour_in      = c;
    v.colour_present = present;
    v.last_vertex    = last;
    return v;
  endfunction

  task automatic send_vertex(vtx_in_t v);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      in_data  <= rand_vertex();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes every register, then an unused index that must be ignored
  task automatic program_all(logic [47:0] rx, logic [47:0] ry, logic [47:0] rz,
                             logic [47:0] sc, logic [47:0] ox, logic [47:0] oy,
                             logic [47:0] oz, logic [47:0] tn);
    write_reg(REG_ROT_X, rx);
    write_reg(REG_ROT_Y, ry);
    write_reg(REG_ROT_Z, rz);
    write_reg(REG_SCALE, sc);
    write_reg(REG_OFFS_X, ox);
    write_reg(REG_OFFS_Y, oy);
    write_reg(REG_OFFS_Z, oz);
    write_reg(REG_TINT, tn);
    write_reg(REG_TINT + CFG_IDX_W'($urandom_range(1, 8)), rand48());
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic send_corners();
    send_vertex(make_vertex(32'sd0, 16'sd0, 32'h0, 1'b1, 1'b0));
    send_vertex(make_vertex(32'sh7FFFFFFF, 16'sh7FFF, 32'hFFFFFFFF, 1'b1, 1'b1));
    send_vertex(make_vertex(32'sh80000000, 16'sh8000, 32'h00000000, 1'b1, 1'b0));
    send_vertex(make_vertex(32'sh00010000, 16'sh4000, 32'h80FF017F, 1'b0, 1'b1));
    send_vertex(make_vertex(-32'sh00018000, -16'sh4000, 32'h12345678, 1'b1, 1'b0));
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings first, then both saturation corners
    send_corners();
    wait_idle();
    program_all({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                48'h0000_7FFFFFFF, 48'h0000_7FFFFFFF, 48'h0000_7FFFFFFF, 48'hF_FFFFFFFFF);
    send_corners();
    wait_idle();
    program_all({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                48'hFFFF_80000000, 48'hFFFF_80000000, 48'hFFFF_80000000, 48'h0);
    send_corners();

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        1: program_all(ROT_X_RST, ROT_Y_RST, ROT_Z_RST, rand48(),
                       rand48(), rand48(), rand48(), rand48());
        4: program_all(rand48(), rand48(), rand48(), SCALE_RST,
                       rand48(), rand48(), rand48(), TINT_RST);
        default: program_all(rand48(), rand48(), rand48(), rand48(),
                             rand48(), rand48(), rand48(), rand48());
      endcase
      quiet <= (ph == 3);
      repeat (PHASE_ITEMS) send_vertex(rand_vertex());
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && in_flight == 0)
      $display("mesh_vertex_transform_core_tb passed");
    else
      $display("mesh_vertex_transform_core_tb failed");
    $finish;
  end

endmodule
